[sv/windowed_peak_envelope_top_defines.svh]
// assertion macros for the asserting files
`ifndef WINDOWED_PEAK_ENVELOPE_TOP_DEFINES_SVH
`define WINDOWED_PEAK_ENVELOPE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WPE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WPE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wpe_pkg.sv]
`default_nettype none

package wpe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 24;
    localparam int WIN_W      = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int DIV_CNT_W  = $clog2(COUNT_W + 1);
    localparam int FULL_SCALE = 1 << (SAMPLE_W - 1);
    localparam int PEAK_FLOOR = (FULL_SCALE * 4 + 99) / 100;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SAMPLE_W-1:0]        mag_t;
    typedef logic [COUNT_W-1:0]         count_t;
    typedef logic [WIN_W-1:0]           win_t;
    typedef logic [DIV_CNT_W-1:0]       div_cnt_t;

    typedef enum logic
    {
        REG_WINDOW_COUNT = 1'b0,
        REG_SAMPLE_COUNT = 1'b1
    } cfg_reg_t;

    // window stepping for the current track
    typedef struct packed
    {
        count_t step_whole;
        win_t   step_fraction;
        win_t   windows;
    } track_t;

endpackage

`default_nettype wire

[sv/wpe_if.sv]
`default_nettype none

interface wpe_sample_if import wpe_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface wpe_peak_if import wpe_pkg::*; ();
    logic valid;
    logic ready;
    win_t window_index;
    mag_t peak;
    logic last_window;

    modport source (output valid, output window_index, output peak, output last_window,
                    input ready);
    modport sink (input valid, input window_index, input peak, input last_window,
                  output ready);
endinterface

`default_nettype wire

[sv/windowed_peak_envelope_top.sv]
// channel    | dir | beat payload
// -----------+-----+---------------------------------------------
// samples    | in  | left_sample, right_sample (signed Q1.15)
// peaks      | out | window_index, peak (unsigned Q1.15), last_window
// apb        | in  | window_count @ 0x0, sample_count @ 0x4
//
// one sample pair per cycle while samples.ready is high; left and right magnitudes come from two lanes
// and a single merge stage updates the peak and the window boundary.
// a register write holds samples.ready low in the access cycle and while the divider
// works out samples per window, one quotient bit a cycle, up to its done strobe.
// rst_n is asynchronous; after reset both registers read 1 and no wait applies.
// a stall on peaks only blocks the beat that closes a window.
`default_nettype none

`include "windowed_peak_envelope_top_defines.svh"

module windowed_peak_envelope_top import wpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    wpe_sample_if.sink        samples,
    wpe_peak_if.source        peaks
);

    win_t     window_count_reg, window_count_next;
    count_t   sample_count_reg, sample_count_next;
    win_t     windows_reg, windows_next;
    cfg_reg_t cfg_sel;
    logic     cfg_write;
    count_t   s_eff;
    win_t     w_eff;
    logic     div_busy;
    logic     div_done;
    count_t   quotient;
    win_t     remainder;
    mag_t     mag_left;
    mag_t     mag_right;
    logic     closing;
    logic     beat;
    track_t   track;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);

    always_comb
    begin
        window_count_next = window_count_reg;
        sample_count_next = sample_count_reg;
        if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_WINDOW_COUNT: window_count_next = pwdata[WIN_W-1:0];
                REG_SAMPLE_COUNT: sample_count_next = pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_WINDOW_COUNT: prdata = DATA_W'(window_count_reg);
            REG_SAMPLE_COUNT: prdata = DATA_W'(sample_count_reg);
            default:          prdata = '0;
        endcase
    end

    // a zero register counts as one; more windows than samples saturates to the sample count
    always_comb
    begin
        s_eff = (sample_count_next == '0) ? count_t'(1) : sample_count_next;
        w_eff = (window_count_next == '0) ? win_t'(1) : window_count_next;
        if (count_t'(w_eff) > s_eff)
            w_eff = s_eff[WIN_W-1:0];
        windows_next = cfg_write ? w_eff : windows_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_count_reg <= win_t'(1);
            sample_count_reg <= count_t'(1);
            windows_reg      <= win_t'(1);
        end
        else
        begin
            window_count_reg <= window_count_next;
            sample_count_reg <= sample_count_next;
            windows_reg      <= windows_next;
        end
    end

    wpe_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_write),
        .dividend  (s_eff),
        .divisor   (w_eff),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    wpe_lane u_lane_left
    (
        .sample (samples.left_sample),
        .mag    (mag_left)
    );

    wpe_lane u_lane_right
    (
        .sample (samples.right_sample),
        .mag    (mag_right)
    );

    assign track.step_whole    = quotient;
    assign track.step_fraction = remainder;
    assign track.windows       = windows_reg;

    assign samples.ready = !div_busy && !cfg_write
                           && (!closing || !peaks.valid || peaks.ready);
    assign beat          = samples.valid && samples.ready;

    wpe_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .mag_left  (mag_left),
        .mag_right (mag_right),
        .restart   (div_done),
        .track     (track),
        .closing   (closing),
        .peaks     (peaks)
    );

    `WPE_ASSERT_NOW(a_no_beat_while_div, div_busy, !samples.ready, "beat taken during divide")
    `WPE_ASSERT_NOW(a_close_needs_room, beat && closing, !peaks.valid || peaks.ready, "result overwritten")
    `WPE_ASSERT_NOW(a_last_index, peaks.valid && peaks.last_window, peaks.window_index == windows_reg - win_t'(1), "last window index wrong")
    `WPE_ASSERT_NEXT(a_div_restart, div_done, !div_busy, "divider still busy after restart")

endmodule

`default_nettype wire

[sv/wpe_lane.sv]
`default_nettype none

module wpe_lane import wpe_pkg::*;
(
    input  sample_t sample,
    output mag_t    mag
);

    // two's complement magnitude; full-scale negative maps to 1.0
    assign mag = sample[SAMPLE_W-1] ? (mag_t'(~sample) + mag_t'(1)) : mag_t'(sample);

endmodule

`default_nettype wire

[sv/wpe_div.sv]
`default_nettype none

module wpe_div import wpe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  count_t dividend,
    input  win_t   divisor,
    output logic   busy,
    output logic   done,
    output count_t quotient,
    output win_t   remainder
);

    div_cnt_t         cnt_reg, cnt_next;
    win_t             rem_reg, rem_next;
    count_t           quo_reg, quo_next;
    win_t             div_reg, div_next;
    logic             done_reg, done_next;
    logic [WIN_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[COUNT_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = div_cnt_t'(COUNT_W);
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? win_t'(trial - {1'b0, div_reg}) : win_t'(trial);
            quo_next  = {quo_reg[COUNT_W-2:0], fits};
            cnt_next  = cnt_reg - div_cnt_t'(1);
            done_next = (cnt_reg == div_cnt_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= count_t'(1);
            div_reg  <= win_t'(1);
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= div_next;
            done_reg <= done_next;
        end
    end

    assign busy      = (cnt_reg != '0) || done_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/wpe_merge.sv]
`default_nettype none

module wpe_merge import wpe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   beat,
    input  mag_t   mag_left,
    input  mag_t   mag_right,
    input  logic   restart,
    input  track_t track,
    output logic   closing,
    wpe_peak_if.source peaks
);

    count_t pos_reg, pos_next;
    win_t   win_reg, win_next;
    count_t end_reg, end_next;
    win_t   rem_reg, rem_next;
    mag_t   run_reg, run_next;
    logic   out_valid_reg, out_valid_next;
    win_t   out_index_reg, out_index_next;
    mag_t   out_peak_reg, out_peak_next;
    logic   out_last_reg, out_last_next;

    mag_t           mag_max;
    mag_t           peak_now;
    mag_t           peak_clamped;
    count_t         pos_inc;
    logic [WIN_W:0] rem_sum;
    logic           wrap;
    logic           last;

    assign mag_max  = (mag_left > mag_right) ? mag_left : mag_right;
    assign peak_now = (mag_max > run_reg) ? mag_max : run_reg;
    assign pos_inc  = pos_reg + count_t'(1);
    assign closing  = (pos_inc == end_reg);
    assign last     = ({1'b0, win_reg} + (WIN_W+1)'(1)) >= {1'b0, track.windows};

    // exact boundary step: whole part plus carried remainder
    assign rem_sum = {1'b0, rem_reg} + {1'b0, track.step_fraction};
    assign wrap    = rem_sum >= {1'b0, track.windows};

    always_comb
    begin
        if (peak_now < mag_t'(PEAK_FLOOR))
            peak_clamped = mag_t'(PEAK_FLOOR);
        else if (peak_now > mag_t'(FULL_SCALE))
            peak_clamped = mag_t'(FULL_SCALE);
        else
            peak_clamped = peak_now;
    end

    always_comb
    begin
        pos_next       = pos_reg;
        win_next       = win_reg;
        end_next       = end_reg;
        rem_next       = rem_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !peaks.ready;
        out_index_next = out_index_reg;
        out_peak_next  = out_peak_reg;
        out_last_next  = out_last_reg;
        priority if (restart)
        begin
            pos_next = '0;
            win_next = '0;
            end_next = track.step_whole;
            rem_next = track.step_fraction;
            run_next = '0;
        end
        else if (beat && !closing)
        begin
            pos_next = pos_inc;
            run_next = peak_now;
        end
        else if (beat)
        begin
            out_valid_next = 1'b1;
            out_index_next = win_reg;
            out_peak_next  = peak_clamped;
            out_last_next  = last;
            run_next       = '0;
            if (last)
            begin
                // track done: scan starts over at position zero
                pos_next = '0;
                win_next = '0;
                end_next = track.step_whole;
                rem_next = track.step_fraction;
            end
            else
            begin
                pos_next = pos_inc;
                win_next = win_reg + win_t'(1);
                end_next = end_reg + track.step_whole + count_t'(wrap);
                rem_next = wrap ? win_t'(rem_sum - {1'b0, track.windows}) : win_t'(rem_sum);
            end
        end
        else
        begin
            // idle cycle: scan state holds
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            win_reg       <= '0;
            end_reg       <= count_t'(1);
            rem_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            win_reg       <= win_next;
            end_reg       <= end_next;
            rem_reg       <= rem_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_peak_reg  <= out_peak_next;
        out_last_reg  <= out_last_next;
    end

    assign peaks.valid        = out_valid_reg;
    assign peaks.window_index = out_index_reg;
    assign peaks.peak         = out_peak_reg;
    assign peaks.last_window  = out_last_reg;

endmodule

`default_nettype wire

[verif/wpe_peak_checker.sv]
module wpe_peak_checker import wpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    wpe_sample_if             smp,
    wpe_peak_if               pk,
    output int                peak_errors,
    output int                peaks_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        win_t index;
        mag_t peak;
        logic last;
    } window_peak_t;

    window_peak_t due_peaks[$];

    // register copies
    win_t   win_reg;
    count_t smp_reg;

    // scan state
    win_t   wins_used;
    count_t step_whole;
    win_t   step_frac;
    win_t   remainder;
    count_t win_end;
    count_t position;
    win_t   cur_win;
    mag_t   run_peak;

    assign peaks_due = due_peaks.size();

    function automatic mag_t q15_magnitude(input sample_t v);
        return v[SAMPLE_W-1] ? mag_t'(~v) + mag_t'(1) : mag_t'(v);
    endfunction

    function void advance_boundary();
        logic [WIN_W:0] acc;
        win_end = win_end + step_whole;
        acc = {1'b0, remainder} + {1'b0, step_frac};
        if (acc >= {1'b0, wins_used})
        begin
            acc = acc - {1'b0, wins_used};
            win_end = win_end + count_t'(1);
        end
        remainder = acc[WIN_W-1:0];
    endfunction

    function void restart_track();
        count_t s;
        count_t w;
        s = (smp_reg == '0) ? count_t'(1) : smp_reg;
        w = (win_reg == '0) ? count_t'(1) : count_t'(win_reg);
        // more windows than samples: one sample per window
        if (w > s)
            w = s;
        wins_used  = win_t'(w);
        step_whole = s / w;
        step_frac  = win_t'(s % w);
        position   = '0;
        cur_win    = '0;
        remainder  = '0;
        win_end    = '0;
        run_peak   = '0;
        advance_boundary();
    endfunction

    function void absorb_pair(input sample_t l, input sample_t r);
        mag_t         a;
        mag_t         b;
        window_peak_t res;
        a = q15_magnitude(l);
        b = q15_magnitude(r);
        if (a > run_peak)
            run_peak = a;
        if (b > run_peak)
            run_peak = b;
        position = position + count_t'(1);
        if (position != win_end)
            return;
        res.index = cur_win;
        res.peak  = (run_peak < mag_t'(PEAK_FLOOR)) ? mag_t'(PEAK_FLOOR) : run_peak;
        if (res.peak > mag_t'(FULL_SCALE))
            res.peak = mag_t'(FULL_SCALE);
        res.last = ({1'b0, cur_win} + 17'd1) >= {1'b0, wins_used};
        due_peaks.push_back(res);
        if (res.last)
            restart_track();
        else
        begin
            cur_win  = cur_win + win_t'(1);
            run_peak = '0;
            advance_boundary();
        end
    endfunction

    function void check_peak(input win_t idx, input mag_t pv, input logic lw);
        window_peak_t exp_beat;
        if (due_peaks.size() == 0)
        begin
            $display("%0t checker: unexpected beat, window %0d peak %0d last %0b",
                     $time, idx, pv, lw);
            peak_errors++;
            return;
        end
        exp_beat = due_peaks.pop_front();
        if (idx !== exp_beat.index)
        begin
            $display("%0t checker: window_index expected %0d got %0d",
                     $time, exp_beat.index, idx);
            peak_errors++;
        end
        if (pv !== exp_beat.peak)
        begin
            $display("%0t checker: peak expected %0d got %0d (window %0d)",
                     $time, exp_beat.peak, pv, exp_beat.index);
            peak_errors++;
        end
        if (lw !== exp_beat.last)
        begin
            $display("%0t checker: last_window expected %0b got %0b (window %0d)",
                     $time, exp_beat.last, lw, exp_beat.index);
            peak_errors++;
        end
    endfunction

    initial
        peak_errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg = win_t'(1);
            smp_reg = count_t'(1);
            due_peaks.delete();
            restart_track();
        end
        else
        begin
            // any register write restarts the track
            if (psel && penable && pwrite && pready)
            begin
                if (cfg_reg_t'(paddr[2]) == REG_WINDOW_COUNT)
                    win_reg = pwdata[WIN_W-1:0];
                else
                    smp_reg = pwdata[COUNT_W-1:0];
                restart_track();
            end
            if (smp.valid && smp.ready)
                absorb_pair(smp.left_sample, smp.right_sample);
            if (pk.valid && pk.ready)
                check_peak(pk.window_index, pk.peak, pk.last_window);
        end
    end

endmodule

[verif/tb.sv]
module tb import wpe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SETTLE_CYCLES = 30;
    localparam int     RANDOM_ITEMS  = 600;
    localparam count_t MAX_SAMPLES   = '1;
    localparam win_t   MAX_WINDOWS   = '1;

    // full scale, floor edges, sign extremes
    localparam sample_t EDGE_LEFT[10] = '{16'sd0, 16'sd32767, 16'sd0, -16'sd32768,
        -16'sd32767, 16'sd1310, 16'sd1311, -16'sd1311, -16'sd1, 16'sd16384};
    localparam sample_t EDGE_RIGHT[10] = '{16'sd0, 16'sd0, -16'sd32768, -16'sd32768,
        16'sd32767, -16'sd5, 16'sd0, 16'sd1312, 16'sd1, -16'sd16385};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                peak_errors;
    int                peaks_due;

    bit hold_req;
    bit steady;
    int burst_left;
    int pairs_sent;

    wpe_sample_if samples();
    wpe_peak_if   peaks();

    windowed_peak_envelope_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples),
        .peaks   (peaks)
    );

    wpe_peak_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .smp         (samples),
        .pk          (peaks),
        .peak_errors (peak_errors),
        .peaks_due   (peaks_due)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic reg_write(input cfg_reg_t r, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // back to idle between transfers
        @(posedge clk);
    endtask

    task automatic send_pair(input sample_t l, input sample_t r);
        int gap;
        if (!steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(12, 30);
                default: gap = $urandom_range(1, 6);
            endcase
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        samples.valid        <= 1'b1;
        samples.left_sample  <= l;
        samples.right_sample <= r;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // let every window close and the pipe go quiet before touching registers
    task automatic drain();
        samples.valid <= 1'b0;
        while (peaks_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5:       v = int'($urandom_range(0, 2800)) - 1400;
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -32767;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = 0;
                endcase
            end
            7:       v = int'($urandom_range(1305, 1316)) * ($urandom_range(0, 1) ? -1 : 1);
            default: v = int'($urandom_range(0, 100)) - 50;
        endcase
        return sample_t'(v);
    endfunction

    task automatic send_random(input int n);
        sample_t l;
        repeat (n)
        begin
            l = pick_sample();
            // mono sources repeat the left channel
            if ($urandom_range(0, 4) == 0)
                send_pair(l, l);
            else
                send_pair(l, pick_sample());
        end
    endtask

    // receiver: random stall patterns, plus one long hold on request
    initial
    begin
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        peaks.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold = 300;
            end
            if (hold > 0)
            begin
                hold--;
                peaks.ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0:       peaks.ready <= 1'b1;
                    1:       peaks.ready <= 1'($urandom_range(0, 1));
                    default: peaks.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int     target;
        int     n;
        count_t cur_s;
        win_t   cur_w;
        logic   [DATA_W-1:0] junk;
        hold_req = 1'b0;
        steady = 1'b0;
        burst_left = 0;
        pairs_sent = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        samples.valid = 1'b0;
        samples.left_sample = '0;
        samples.right_sample = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one sample per track after reset: every beat is its own window
        for (int i = 0; i < 10; i++)
            send_pair(EDGE_LEFT[i], EDGE_RIGHT[i]);
        drain();

        // zero in both registers behaves as one
        reg_write(REG_WINDOW_COUNT, '0);
        reg_write(REG_SAMPLE_COUNT, '0);
        send_pair(16'sd5, -16'sd7);
        send_pair(-16'sd20000, 16'sd3);
        drain();

        // more windows than samples
        reg_write(REG_WINDOW_COUNT, 32'd9);
        reg_write(REG_SAMPLE_COUNT, 32'd4);
        send_random(5);
        drain();

        // uneven windows, remainder carries
        reg_write(REG_WINDOW_COUNT, 32'd3);
        reg_write(REG_SAMPLE_COUNT, 32'd7);
        send_random(7);
        drain();

        // long hold on the peak side while samples stay offered without gaps
        reg_write(REG_WINDOW_COUNT, 32'd1);
        reg_write(REG_SAMPLE_COUNT, 32'd1);
        cur_s = count_t'(1);
        cur_w = win_t'(1);
        hold_req = 1'b1;
        steady = 1'b1;
        send_random(60);
        steady = 1'b0;
        drain();

        target = pairs_sent + RANDOM_ITEMS;
        while (pairs_sent < target)
        begin
            case ($urandom_range(0, 11))
                0:
                begin
                    cur_s = MAX_SAMPLES;
                    cur_w = MAX_WINDOWS;
                end
                1:
                begin
                    cur_s = MAX_SAMPLES;
                    cur_w = win_t'(1);
                end
                2:
                begin
                    cur_s = count_t'($urandom_range(1, 40));
                    cur_w = MAX_WINDOWS;
                end
                3:
                begin
                    cur_s = count_t'($urandom_range(1, 8));
                    cur_w = win_t'(cur_s);
                end
                4:
                begin
                    cur_s = count_t'($urandom_range(0, 3));
                    cur_w = win_t'($urandom_range(0, 3));
                end
                default:
                begin
                    cur_s = count_t'($urandom_range(1, 120));
                    cur_w = win_t'($urandom_range(1, int'(cur_s) + 5));
                end
            endcase
            // upper data bits are don't-care for both registers
            junk = $urandom;
            if ($urandom_range(0, 1))
            begin
                reg_write(REG_SAMPLE_COUNT, {junk[DATA_W-1:COUNT_W], cur_s});
                if ($urandom_range(0, 4) != 0)
                    reg_write(REG_WINDOW_COUNT, {junk[DATA_W-1:WIN_W], cur_w});
            end
            else
            begin
                reg_write(REG_WINDOW_COUNT, {junk[DATA_W-1:WIN_W], cur_w});
                reg_write(REG_SAMPLE_COUNT, {junk[DATA_W-1:COUNT_W], cur_s});
            end
            // one or two whole tracks plus a partial one; tracks over 80 samples get a random slice
            if (cur_s > count_t'(80))
                n = $urandom_range(100, 160);
            else
            begin
                n = int'(cur_s == '0 ? count_t'(1) : cur_s);
                n = n * $urandom_range(1, 2) + $urandom_range(0, n);
            end
            send_random(n);
            drain();
        end

        if (peak_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
